@@ src/fcbpa_pkg.sv @@
// Shared types, codes and helpers for the four-class block pool allocator.
`timescale 1ns / 1ps

package fcbpa_pkg;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 16;
	localparam int ADDR_W  = 30;
	localparam int ST_W    = 2;
	localparam int CLS_W   = 2;
	localparam int HW_W    = 13;
	localparam int HEAD_W  = 14;  // holds a block count up to 8192
	localparam int REL_W   = ADDR_W + 1;  // offset into pool plus borrow bit
	localparam int WORDS_W = SIZE_W - 2;
	localparam int IN_W    = 48;  // cmd + size_bytes + block_addr, exactly 48 bits with no padding
	localparam int OUT_W   = 48;  // status + addr + size_class + high_water, byte padded

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [ST_W-1:0]   status_t;
	typedef logic [CLS_W-1:0]  cls_t;
	typedef logic [HEAD_W-1:0] head_t;

	// Operation codes
	localparam cmd_t CMD_ALLOC  = 2'd0;
	localparam cmd_t CMD_FREE   = 2'd1;
	localparam cmd_t CMD_FORMAT = 2'd2;

	// Status codes
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_TOO_BIG = 2'd1;
	localparam status_t ST_EMPTY   = 2'd2;
	localparam status_t ST_OUTSIDE = 2'd3;

	// Block sizes in words per class
	localparam logic [WORDS_W-1:0] BLK_WORDS0 = 14'h0040;
	localparam logic [WORDS_W-1:0] BLK_WORDS1 = 14'h0100;
	localparam logic [WORDS_W-1:0] BLK_WORDS2 = 14'h0400;
	localparam logic [WORDS_W-1:0] BLK_WORDS3 = 14'h0800;

	localparam int SHIFT0 = 6;
	localparam int SHIFT1 = 8;
	localparam int SHIFT2 = 10;
	localparam int SHIFT3 = 11;

	localparam head_t HW_MAX = 14'd8191;

	// log2 of the block size for a class
	function automatic logic [3:0] blk_shift(input cls_t c);
		logic [3:0] s;
		case (c)
			2'd0:    s = 4'(SHIFT0);
			2'd1:    s = 4'(SHIFT1);
			2'd2:    s = 4'(SHIFT2);
			default: s = 4'(SHIFT3);
		endcase
		return s;
	endfunction

	// High-water mark as reported, saturated to the output width
	function automatic logic [HW_W-1:0] hw_sat(input head_t p);
		logic [HW_W-1:0] r;
		if (p > HW_MAX) r = HW_MAX[HW_W-1:0];
		else            r = p[HW_W-1:0];
		return r;
	endfunction

endpackage

@@ src/fcbpa_link_ram.sv @@
// Single-port-write, single-port-read link memory with registered read data.
`timescale 1ns / 1ps

module fcbpa_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule

@@ src/four_class_block_pool_allocator.sv @@
// Top level of the four-class block pool allocator.
`timescale 1ns / 1ps

// Allocates and frees fixed-size blocks of 64, 256, 1024 and 2048 words from
// a pool that starts at pool_base_word (written through cfg_we / cfg_wdata;
// write it only while the block is idle, which the block does not enforce).
// Each class keeps a LIFO free list whose links live in a synchronous memory
// per class. Allocate and free use an accept cycle, which issues the link
// read, and an execute cycle, which updates head, peak and link and loads the
// result register. A result word that is not taken holds the block in the
// execute cycle until m_tready. Format and the pass that follows reset
// rewrite every link entry, one index per cycle in all four memories at once,
// over the indices below max(COUNT_CLASS0..3). After reset that sweep alone
// keeps s_tready low; a format word passes through the execute cycle, the
// sweep and the result state S_FMTOUT, and no input word is taken meanwhile.
module four_class_block_pool_allocator #(
	parameter int COUNT_CLASS0 = 4096,
	parameter int COUNT_CLASS1 = 1024,
	parameter int COUNT_CLASS2 = 128,
	parameter int COUNT_CLASS3 = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// pool_base_word
	input  logic                         cfg_we,
	input  logic [fcbpa_pkg::ADDR_W-1:0] cfg_wdata,
	// input words
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd[1:0], size_bytes[17:2], block_addr[47:18]
	input  logic [fcbpa_pkg::IN_W-1:0]   s_tdata,
	// result words
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[1:0], addr[31:2], size_class[33:32], high_water[46:34], zero[47]
	output logic [fcbpa_pkg::OUT_W-1:0]  m_tdata
);
	import fcbpa_pkg::*;

	localparam int CNT [4] = '{COUNT_CLASS0, COUNT_CLASS1, COUNT_CLASS2, COUNT_CLASS3};
	localparam int MAX01 = (COUNT_CLASS0 > COUNT_CLASS1) ? COUNT_CLASS0 : COUNT_CLASS1;
	localparam int MAX23 = (COUNT_CLASS2 > COUNT_CLASS3) ? COUNT_CLASS2 : COUNT_CLASS3;
	localparam int MAXC  = (MAX01 > MAX23) ? MAX01 : MAX23;
	localparam int SW    = (MAXC > 1) ? $clog2(MAXC) : 1;

	// class start offsets from the pool base, in words
	localparam logic [REL_W-1:0] OFF1 = REL_W'(COUNT_CLASS0 << SHIFT0);
	localparam logic [REL_W-1:0] OFF2 = OFF1 + REL_W'(COUNT_CLASS1 << SHIFT1);
	localparam logic [REL_W-1:0] OFF3 = OFF2 + REL_W'(COUNT_CLASS2 << SHIFT2);
	localparam logic [REL_W-1:0] OFF_END = OFF3 + REL_W'(COUNT_CLASS3 << SHIFT3);
	localparam logic [REL_W-1:0] OFFV [4] = '{'0, OFF1, OFF2, OFF3};

	localparam head_t CNTV [4] = '{HEAD_W'(COUNT_CLASS0), HEAD_W'(COUNT_CLASS1),
		HEAD_W'(COUNT_CLASS2), HEAD_W'(COUNT_CLASS3)};

	// state codes
	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_EXEC   = 2'd2;
	localparam logic [1:0] S_FMTOUT = 2'd3;

	logic [1:0]        state_q;
	logic [SW-1:0]     sweep_q;
	logic              fmt_pend_q;
	logic [ADDR_W-1:0] base_q;
	head_t             head_q [4];
	head_t             peak_q [4];

	// accepted word, decoded
	cmd_t              cmd_s1;
	logic              too_big_s1;
	logic              empty_s1;
	cls_t              cls_s1;
	logic [ADDR_W-1:0] aoff_s1;
	logic [REL_W-1:0]  rel_s1;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// input field split
	cmd_t               in_cmd;
	logic [SIZE_W-1:0]  in_size;
	logic [ADDR_W-1:0]  in_baddr;
	logic [WORDS_W-1:0] words;
	logic               in_too_big;
	cls_t               in_cls;
	head_t              in_head;
	logic               in_empty;
	logic [REL_W-1:0]   in_aoff;
	logic [REL_W-1:0]   in_rel;
	logic               accept;

	assign in_cmd   = s_tdata[1:0];
	assign in_size  = s_tdata[17:2];
	assign in_baddr = s_tdata[47:18];
	assign words    = in_size[SIZE_W-1:2];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	// allocate: pick class by size, look at its head
	always_comb begin
		in_too_big = 1'b0;
		if      (words <= BLK_WORDS0) in_cls = 2'd0;
		else if (words <= BLK_WORDS1) in_cls = 2'd1;
		else if (words <= BLK_WORDS2) in_cls = 2'd2;
		else if (words <= BLK_WORDS3) in_cls = 2'd3;
		else begin
			in_cls     = 2'd0;
			in_too_big = 1'b1;
		end
		in_head  = head_q[in_cls];
		in_empty = (in_head >= CNTV[in_cls]);
		in_aoff  = OFFV[in_cls] + (REL_W'(in_head) << blk_shift(in_cls));
		in_rel   = {1'b0, in_baddr} - {1'b0, base_q};
	end

	// link memories: read data per class, zero-extended
	head_t  rd_ext [4];
	logic   clearing;
	logic   commit_free;
	head_t  free_idx;
	cls_t   fcls;
	logic   out_free;
	logic [SW:0] sweep_inc;

	assign clearing  = (state_q == S_CLEAR);
	assign out_free  = !out_valid_q || m_tready;
	assign sweep_inc = {1'b0, sweep_q} + 1'b1;

	for (genvar g = 0; g < 4; g++) begin : g_cls
		localparam int IW = (CNT[g] > 1) ? $clog2(CNT[g]) : 1;
		localparam int LW = $clog2(CNT[g] + 1);

		logic          we;
		logic [IW-1:0] waddr;
		logic [LW-1:0] wdata;
		logic          re;
		logic [LW-1:0] rdata;

		// clear pass writes k+1 at k; free pushes the old head
		always_comb begin
			if (clearing) begin
				we    = ({1'b0, sweep_q} < (SW + 1)'(CNT[g]));
				waddr = sweep_q[IW-1:0];
				wdata = LW'(sweep_inc);
			end else begin
				we    = commit_free && (fcls == cls_t'(g));
				waddr = free_idx[IW-1:0];
				wdata = LW'(head_q[fcls]);
			end
		end

		assign re = accept && (in_cmd == CMD_ALLOC) && !in_too_big && !in_empty
			&& (in_cls == cls_t'(g));

		fcbpa_link_ram #(
			.DEPTH(CNT[g]),
			.WIDTH(LW)
		) u_links (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(wdata),
			.re   (re),
			.raddr(in_head[IW-1:0]),
			.rdata(rdata)
		);

		assign rd_ext[g] = HEAD_W'(rdata);
	end

	// execute stage: new head, new peak, free decode, result
	head_t             nh_raw;
	head_t             nh;
	head_t             new_peak;
	logic              outside;
	logic [REL_W-1:0]  idx_full;
	status_t           res_status;
	logic [ADDR_W-1:0] res_addr;
	cls_t              res_cls;
	logic [HW_W-1:0]   res_hw;
	logic              commit;

	always_comb begin
		nh_raw   = rd_ext[cls_s1];
		nh       = (nh_raw > CNTV[cls_s1]) ? CNTV[cls_s1] : nh_raw;
		new_peak = (nh > peak_q[cls_s1]) ? nh : peak_q[cls_s1];

		outside = rel_s1[REL_W-1] || (rel_s1 >= OFF_END);
		if      (rel_s1 >= OFF3) fcls = 2'd3;
		else if (rel_s1 >= OFF2) fcls = 2'd2;
		else if (rel_s1 >= OFF1) fcls = 2'd1;
		else                     fcls = 2'd0;
		// offset into the class first, then truncate to a block index
		idx_full = (rel_s1 - OFFV[fcls]) >> blk_shift(fcls);
		free_idx = idx_full[HEAD_W-1:0];

		res_status = ST_OK;
		res_addr   = '0;
		res_cls    = '0;
		res_hw     = '0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (too_big_s1) begin
					res_status = ST_TOO_BIG;
				end else if (empty_s1) begin
					res_status = ST_EMPTY;
					res_cls    = cls_s1;
					res_hw     = hw_sat(peak_q[cls_s1]);
				end else begin
					res_addr = base_q + aoff_s1;
					res_cls  = cls_s1;
					res_hw   = hw_sat(new_peak);
				end
			end
			CMD_FREE: begin
				if (outside) begin
					res_status = ST_OUTSIDE;
				end else begin
					res_cls = fcls;
					res_hw  = hw_sat(peak_q[fcls]);
				end
			end
			default: ;
		endcase
	end

	assign commit      = (state_q == S_EXEC) && out_free && (cmd_s1 != CMD_FORMAT);
	assign commit_free = commit && (cmd_s1 == CMD_FREE) && !outside;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_we) base_q <= cfg_wdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			sweep_q    <= '0;
			fmt_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sweep_q == SW'(MAXC - 1)) begin
						sweep_q <= '0;
						state_q <= fmt_pend_q ? S_FMTOUT : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd_s1 == CMD_FORMAT) begin
						state_q    <= S_CLEAR;
						fmt_pend_q <= 1'b1;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FMTOUT: begin
					if (out_free) begin
						state_q    <= S_IDLE;
						fmt_pend_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// accepted word held for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= in_cmd;
			too_big_s1 <= in_too_big;
			empty_s1   <= in_empty;
			cls_s1     <= in_cls;
			aoff_s1    <= in_aoff[ADDR_W-1:0];
			rel_s1     <= in_rel;
		end
	end

	// per-class head and high-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				head_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else if ((state_q == S_EXEC) && (cmd_s1 == CMD_FORMAT)) begin
			for (int i = 0; i < 4; i++) begin
				head_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else if (commit && (cmd_s1 == CMD_ALLOC) && !too_big_s1 && !empty_s1) begin
			head_q[cls_s1] <= nh;
			peak_q[cls_s1] <= new_peak;
		end else if (commit_free) begin
			head_q[fcls] <= free_idx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit || ((state_q == S_FMTOUT) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {1'b0, res_hw, res_cls, res_addr, res_status};
		end else if ((state_q == S_FMTOUT) && out_free) begin
			out_data_q <= {1'b0, {HW_W{1'b0}}, {CLS_W{1'b0}}, {ADDR_W{1'b0}}, ST_OK};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule

@@ src/fcbpa_checker.sv @@
// Port-level checks on the allocator's result stream, bound to the top level.
`timescale 1ns / 1ps

module fcbpa_port_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [fcbpa_pkg::OUT_W-1:0] m_tdata
);
	import fcbpa_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// an address only comes with a successful operation
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[31:2] == '0))
		else $error("address on a failed operation");

	// size and range errors carry no class and no mark
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[1:0] == ST_TOO_BIG) || (m_tdata[1:0] == ST_OUTSIDE))
		|-> (m_tdata[46:32] == '0))
		else $error("class or mark on a size or range error");

	// padding bit stays clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[47])
		else $error("padding bit set in result word");
endmodule

bind four_class_block_pool_allocator fcbpa_port_checker u_fcbpa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
